// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the range drop-off detector.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/rdd_pkg.sv -----
// Package for the range drop-off detector: register indexes, reset values
// and fixed-point constants. Depends on nothing.
package rdd_pkg;

	localparam int unsigned THR_W    = 12;
	localparam int unsigned RUN_W    = 8;
	localparam int unsigned MAX_W    = 12;
	localparam int unsigned CFG_W    = 12;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned BASE_W   = 16;

	typedef enum logic [1:0] {
		REG_RISE_THRESHOLD = 2'd0,
		REG_MIN_RUN_LENGTH = 2'd1,
		REG_MAX_TRUSTED    = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_index_t;

	localparam logic [THR_W-1:0] RISE_THRESHOLD_RST = 12'd200;
	localparam logic [RUN_W-1:0] MIN_RUN_LENGTH_RST = 8'd3;
	localparam logic [MAX_W-1:0] MAX_TRUSTED_RST    = 12'd3500;
	localparam logic [RUN_W-1:0] RUN_MAX            = 8'd255;

	// x / 10 == (x * 0xCCCD) >> 19, exact for any 16-bit unsigned x
	localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
	localparam int unsigned DIV10_SHIFT = 19;

endpackage

// ----- hdl/range_dropoff_detector_core.sv -----
// Range drop-off detector, top level: input register, baseline/streak
// update and output register. Depends on rdd_pkg and assert_macros.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | in_valid/in_stall  | range_sample_mm (signed 16 bit)
//  output   | out_valid/out_stall| dropoff_flag (1 bit)
//  config   | cfg_we             | cfg_index (2 bit), cfg_wdata (12 bit)
//
// One transaction per cycle sustained while out_stall is low; a sample
// passes the input register, then the result register, before its result
// transaction is offered.
// The baseline update (subtract, constant multiply by 1/10, add) fits in
// the single stage between the two registers.
// arst_n clears the valid bits, the baseline state and the config registers
// to their reset values. A stalled output holds its result and backs up into
// the input register, which raises in_stall only while it holds an item.
`include "assert_macros.svh"

module range_dropoff_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input transaction
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rdd_pkg::SAMPLE_W-1:0] range_sample_mm,
	// result transaction
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                dropoff_flag,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [rdd_pkg::CFG_W-1:0]           cfg_wdata
);

	// config registers
	logic [rdd_pkg::THR_W-1:0] rise_threshold_q;
	logic [rdd_pkg::RUN_W-1:0] min_run_q;
	logic [rdd_pkg::MAX_W-1:0] max_trusted_q;

	// tracking state
	logic [rdd_pkg::BASE_W-1:0] baseline_q;
	logic                       ready_q;
	logic [rdd_pkg::RUN_W-1:0]  run_q;

	// input stage
	logic                                valid_s1;
	logic signed [rdd_pkg::SAMPLE_W-1:0] sample_s1;

	// output stage
	logic out_valid_q;
	logic flag_q;

	// handshake
	logic out_free;
	logic advance;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign out_valid    = out_valid_q;
	assign dropoff_flag = flag_q;

	// ---- update datapath ----
	logic                       trusted;
	logic [rdd_pkg::BASE_W-1:0] sample_q4;
	logic signed [16:0]         diff;
	logic signed [16:0]         thr_q4;
	logic                       over;
	logic [16:0]                diff_neg;
	logic [15:0]                diff_mag;
	logic [31:0]                div_prod;
	logic [15:0]                step_mag;
	logic [rdd_pkg::BASE_W-1:0] baseline_upd;
	logic [rdd_pkg::RUN_W-1:0]  run_inc;

	// untrusted: negative, or above the trusted maximum
	assign trusted = !sample_s1[15]
		&& (sample_s1[14:0] <= {3'b000, max_trusted_q});

	// trusted samples are below 4096, so the Q12.4 form fits 16 bits
	assign sample_q4 = {sample_s1[11:0], 4'b0000};
	assign diff      = $signed({1'b0, sample_q4}) - $signed({1'b0, baseline_q});
	assign thr_q4    = $signed({1'b0, rise_threshold_q, 4'b0000});
	assign over      = diff > thr_q4;

	// step = diff / 10, truncated toward zero: divide the magnitude
	assign diff_neg = 17'(-diff);
	assign diff_mag = diff[16] ? diff_neg[15:0] : diff[15:0];
	assign div_prod = diff_mag * rdd_pkg::DIV10_MULT;
	assign step_mag = 16'(div_prod >> rdd_pkg::DIV10_SHIFT);

	assign baseline_upd = diff[16] ? (baseline_q - step_mag) : (baseline_q + step_mag);
	assign run_inc      = (run_q == rdd_pkg::RUN_MAX) ? run_q : (run_q + 8'd1);

	logic [rdd_pkg::RUN_W-1:0]  run_next;
	logic [rdd_pkg::BASE_W-1:0] baseline_next;
	logic                       ready_next;
	logic                       flag_next;

	always_comb begin
		run_next      = '0;
		baseline_next = baseline_q;
		ready_next    = ready_q;
		flag_next     = 1'b0;
		priority if (!trusted) begin
			run_next = '0;
		end else if (!ready_q) begin
			// seeding sample
			baseline_next = sample_q4;
			ready_next    = 1'b1;
		end else if (over) begin
			// baseline frozen while floor looks missing
			run_next  = run_inc;
			flag_next = run_inc >= min_run_q;
		end else begin
			baseline_next = baseline_upd;
			flag_next     = min_run_q == '0;
		end
	end

	// ---- config ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_threshold_q <= rdd_pkg::RISE_THRESHOLD_RST;
			min_run_q        <= rdd_pkg::MIN_RUN_LENGTH_RST;
			max_trusted_q    <= rdd_pkg::MAX_TRUSTED_RST;
		end else if (cfg_we) begin
			unique case (rdd_pkg::reg_index_t'(cfg_index))
				rdd_pkg::REG_RISE_THRESHOLD: rise_threshold_q <= cfg_wdata;
				rdd_pkg::REG_MIN_RUN_LENGTH: min_run_q <= cfg_wdata[rdd_pkg::RUN_W-1:0];
				rdd_pkg::REG_MAX_TRUSTED:    max_trusted_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---- control and state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			baseline_q  <= '0;
			ready_q     <= 1'b0;
			run_q       <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				baseline_q  <= baseline_next;
				ready_q     <= ready_next;
				run_q       <= run_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload ----
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= range_sample_mm;
		end
		if (advance) begin
			flag_q <= flag_next;
		end
	end

	// ---- checks ----
	`ASSERT_SAME(a_flag_needs_seed, clk, arst_n, out_valid_q && flag_q, ready_q)
	`ASSERT_SAME(a_run_needs_seed, clk, arst_n, run_q != '0, ready_q)
	`ASSERT_NEXT(a_untrusted_clears, clk, arst_n, advance && !trusted, run_q == '0)
	`ASSERT_NEXT(a_take_fills_s1, clk, arst_n, in_take, valid_s1)

endmodule

// ----- test/tb_range_dropoff_detector_core.sv -----
// Testbench for range_dropoff_detector_core: directed sample table, then random
// sample streams under several register settings, checked against a predictor.
// Depends on rdd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb_range_dropoff_detector_core;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1700;
	localparam int LONG_HOLD   = 250;   // receiver hold-off, in cycles
	localparam int STEP_DIV    = 10;    // baseline moves 1/10 of the way
	localparam int REPORT_MAX  = 10;

	// local copies of the package widths used in size casts
	localparam int unsigned SAMPLE_W = rdd_pkg::SAMPLE_W;
	localparam int unsigned CFG_W    = rdd_pkg::CFG_W;
	localparam int unsigned BASE_W   = rdd_pkg::BASE_W;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] range_sample_mm;
	logic                       out_valid;
	logic                       out_stall;
	logic                       dropoff_flag;
	logic                       cfg_we;
	logic [1:0]                 cfg_index;
	logic [CFG_W-1:0]           cfg_wdata;

	range_dropoff_detector_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.range_sample_mm (range_sample_mm),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dropoff_flag    (dropoff_flag),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the registers and of the baseline/streak state
	// ------------------------------------------------------------------
	logic [rdd_pkg::THR_W-1:0] rise_thr;
	logic [rdd_pkg::RUN_W-1:0] min_run;
	logic [rdd_pkg::MAX_W-1:0] max_trusted;
	logic [BASE_W-1:0]         base_q4;
	logic                      base_ready;
	logic [rdd_pkg::RUN_W-1:0] streak;

	// Advance the predicted state by one sample, return the expected flag.
	function automatic logic predict_dropoff(input logic signed [SAMPLE_W-1:0] smp);
		int s;
		int s_q4;
		int resid;
		s = smp;
		// negative or beyond the trusted range: streak clears, baseline kept
		if (s < 0 || s > int'(max_trusted)) begin
			streak = '0;
			return 1'b0;
		end
		s_q4 = s * 16;
		// first trusted sample seeds the baseline and never flags
		if (!base_ready) begin
			base_q4    = s_q4[BASE_W-1:0];
			base_ready = 1'b1;
			streak     = '0;
			return 1'b0;
		end
		resid = s_q4 - int'(base_q4);
		if (resid > int'(rise_thr) * 16) begin
			// floor missing: count up, baseline frozen
			if (streak != rdd_pkg::RUN_MAX)
				streak = streak + 1'b1;
		end else begin
			streak  = '0;
			base_q4 = BASE_W'(int'(base_q4) + resid / STEP_DIV);   // truncates to zero
		end
		return streak >= min_run;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: one expected flag per accepted sample, in order
	// ------------------------------------------------------------------
	logic pending_flags [$];
	int   mismatches = 0;
	int   items_sent = 0;

	// table rows carry a typed-in flag; everything else uses the predictor
	logic row_known;
	logic row_flag;

	task automatic note_mismatch(input string what, input logic want, input logic got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s: expected %b, got %b", $time, what, want, got);
	endtask

	always @(posedge clk) begin : monitor
		logic want;
		logic pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_flags.size() == 0)
					note_mismatch("result transaction with nothing pending", 1'bx,
						dropoff_flag);
				else begin
					want = pending_flags.pop_front();
					if (dropoff_flag !== want)
						note_mismatch("dropoff_flag", want, dropoff_flag);
				end
			end
			if (in_valid && !in_stall) begin
				pred = predict_dropoff(range_sample_mm);
				pending_flags.push_back(row_known ? row_flag : pred);
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------
	bit rx_idle_en     = 1'b0;
	bit sender_idle_en = 1'b0;
	int hold_reqs      = 0;
	int holds_done     = 0;
	int hold_left      = 0;

	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_done != hold_reqs) begin
			holds_done++;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= rx_idle_en && ($urandom_range(99) < 10);
	end

	// watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender and register writes
	// ------------------------------------------------------------------
	// Present one sample at the falling edge, hold it until taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic known,
		input logic flag);
		while (sender_idle_en && $urandom_range(99) < 10) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		range_sample_mm <= smp;
		row_known       <= known;
		row_flag        <= flag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every result is back.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_flags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input rdd_pkg::reg_index_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			rdd_pkg::REG_RISE_THRESHOLD: rise_thr    = val[rdd_pkg::THR_W-1:0];
			rdd_pkg::REG_MIN_RUN_LENGTH: min_run     = val[rdd_pkg::RUN_W-1:0];
			rdd_pkg::REG_MAX_TRUSTED:    max_trusted = val[rdd_pkg::MAX_W-1:0];
			default: ;   // unused index: write dropped
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] run,
		input logic [CFG_W-1:0] maxv);
		wait_idle();
		write_reg(rdd_pkg::REG_RISE_THRESHOLD, thr);
		write_reg(rdd_pkg::REG_MIN_RUN_LENGTH, run);
		write_reg(rdd_pkg::REG_MAX_TRUSTED, maxv);
	endtask

	// ------------------------------------------------------------------
	// Random sample source, steered by the predicted baseline so that runs
	// of over-threshold samples actually build up streaks.
	// ------------------------------------------------------------------
	int burst_left = 0;

	function automatic logic [SAMPLE_W-1:0] next_sample();
		int base_mm;
		int thr;
		int top;
		int lo;
		int hi;
		int r;
		base_mm = int'(base_q4) >> 4;
		thr     = rise_thr;
		top     = max_trusted;
		r       = $urandom_range(99);
		if (burst_left == 0 && r >= 20 && r < 45)
			burst_left = $urandom_range((int'(min_run) + 2 > 30) ? 30 : int'(min_run) + 2, 1);
		if (burst_left > 0) begin
			burst_left--;
			lo = base_mm + thr + 1;
			if (lo > top)
				return SAMPLE_W'(top);
			hi = (top < lo + 300) ? top : lo + 300;
			return SAMPLE_W'($urandom_range(hi, lo));
		end
		if (r < 8)
			return SAMPLE_W'($urandom);
		if (r < 14)
			return SAMPLE_W'($urandom_range(top, 0));
		if (r < 20) begin
			case ($urandom_range(3))
				0: return SAMPLE_W'(top);
				1: return SAMPLE_W'(top + 1);
				2: return '0;
				default: return '1;
			endcase
		end
		// near the baseline: mostly under the threshold
		lo = base_mm - thr - 5;
		hi = base_mm + thr;
		if (lo < 0) lo = 0;
		if (hi > top) hi = top;
		if (lo > hi)
			return SAMPLE_W'(top);
		return SAMPLE_W'($urandom_range(hi, lo));
	endfunction

	task automatic run_random(input int n);
		repeat (n)
			send_sample(next_sample(), 1'b0, 1'b0);
	endtask

	task automatic random_config();
		set_config(CFG_W'($urandom_range(600)), CFG_W'($urandom_range(8, 1)),
			CFG_W'($urandom_range(4095, 1500)));
	endtask

	// ------------------------------------------------------------------
	// Directed table, default registers (threshold 200, run 3, max 3500)
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic                known;
		logic                flag;
	} dir_row_t;

	dir_row_t dir_rows [0:16] = '{
		'{16'h8000, 1'b1, 1'b0},   // most negative: untrusted
		'{16'h7FFF, 1'b1, 1'b0},   // most positive: untrusted
		'{16'd3501, 1'b1, 1'b0},   // one past max trusted
		'{16'hFFFF, 1'b1, 1'b0},   // -1
		'{16'd3500, 1'b1, 1'b0},   // seeds baseline at max trusted
		'{16'd0,    1'b0, 1'b0},   // baseline pulled down
		'{16'd0,    1'b0, 1'b0},
		'{16'd4095, 1'b1, 1'b0},   // untrusted, baseline kept
		'{16'd3500, 1'b0, 1'b0},   // streak builds past the minimum
		'{16'd3500, 1'b0, 1'b0},
		'{16'd3500, 1'b0, 1'b0},
		'{16'd3500, 1'b0, 1'b0},
		'{16'hFFFF, 1'b1, 1'b0},   // untrusted clears the streak
		'{16'd3500, 1'b0, 1'b0},
		'{16'd2835, 1'b0, 1'b0},   // near baseline
		'{16'd1,    1'b0, 1'b0},
		'{16'h7FFF, 1'b1, 1'b0}
	};

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		range_sample_mm = '0;
		out_stall       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = rdd_pkg::REG_RISE_THRESHOLD;
		cfg_wdata       = '0;
		row_known       = 1'b0;
		row_flag        = 1'b0;
		rise_thr        = rdd_pkg::RISE_THRESHOLD_RST;
		min_run         = rdd_pkg::MIN_RUN_LENGTH_RST;
		max_trusted     = rdd_pkg::MAX_TRUSTED_RST;
		base_q4         = '0;
		base_ready      = 1'b0;
		streak          = '0;

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_en = 1'b1;
		rx_idle_en     = 1'b1;
		for (int i = 0; i < 17; i++)
			send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].flag);

		// long stretch with no idling on either side, reset registers
		wait_idle();
		sender_idle_en = 1'b0;
		rx_idle_en     = 1'b0;
		run_random(400);

		// low extremes: zero threshold, run of one, widest trusted range
		sender_idle_en = 1'b1;
		rx_idle_en     = 1'b1;
		set_config('0, CFG_W'(1), CFG_W'(4095));
		run_random(250);

		// high extremes; run written with spare upper bits set (keeps 255)
		set_config(CFG_W'(4095), '1, '0);
		run_random(80);

		// zero minimum run (upper bits dropped), and a write to the spare index
		set_config(CFG_W'($urandom_range(400)), CFG_W'(12'hF00),
			CFG_W'($urandom_range(4095, 2000)));
		write_reg(rdd_pkg::REG_UNUSED, CFG_W'($urandom));
		run_random(200);

		// streak saturation: pull baseline low, then a run longer than 255
		set_config(CFG_W'(10), CFG_W'(255), CFG_W'(4095));
		repeat (60)
			send_sample('0, 1'b0, 1'b0);
		burst_left = 300;
		run_random(320);

		// receiver holds off while samples keep coming: input must back up
		random_config();
		hold_reqs++;
		run_random(150);

		while (items_sent < ITEM_TARGET) begin
			random_config();
			sender_idle_en = $urandom_range(1);
			rx_idle_en     = $urandom_range(1);
			run_random(150);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rdd_pkg.sv
hdl/range_dropoff_detector_core.sv
test/tb_range_dropoff_detector_core.sv
